// ===== src/bchc_pkg.sv =====
// Package for the button click/hold classifier.
// Holds the configuration register indexes, reset values, event codes and
// the configuration bundle type. No dependencies.
`default_nettype none

package bchc_pkg;

  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned EventW = 3;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegDebounce = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDblGap   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegHold     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLongHold = 3'd3;

  // Reset values
  localparam logic [CfgW-1:0] DebounceRst = 16'd20;
  localparam logic [CfgW-1:0] DblGapRst   = 16'd150;
  localparam logic [CfgW-1:0] HoldRst     = 16'd1000;
  localparam logic [CfgW-1:0] LongHoldRst = 16'd2000;

  // Event codes
  localparam logic [EventW-1:0] EvNone   = 3'd0;
  localparam logic [EventW-1:0] EvClick  = 3'd1;
  localparam logic [EventW-1:0] EvDouble = 3'd2;
  localparam logic [EventW-1:0] EvHold   = 3'd3;
  localparam logic [EventW-1:0] EvLong   = 3'd4;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] double_click_gap_ms;
    logic [CfgW-1:0] hold_ms;
    logic [CfgW-1:0] long_hold_ms;
  } cfg_t;

endpackage

`default_nettype wire

// ===== src/button_click_hold_classifier.sv =====
// Button click/hold classifier: one event code per sampled button level.
//
// Input channel (in_valid_i/in_ready_o) carries level_i (0 pressed,
// 1 released) and a free-running millisecond stamp now_ms_i. Each input
// transaction produces exactly one output transaction on
// (out_valid_o/out_ready_i) with event_res_o: 0 none, 1 click, 2 double
// click, 3 hold, 4 long hold.
// Sample path: input register -> classifier logic -> result register.
// One sample is taken every cycle while the receiver keeps up.
// When the receiver stalls, the result register holds and in_ready_o drops
// once the input register is also full; nothing is lost.
// Reset clears both register stages and restores the classifier state and
// the four timing registers (20, 150, 1000, 2000 ms). The user must write the
// timing registers through cfg_we_i/cfg_idx_i/cfg_wdata_i only while the block
// is idle; the block does not enforce it. Indexes 4 and up are ignored.
// Depends on bchc_pkg, bchc_cfg and bchc_core.
`default_nettype none

module button_click_hold_classifier (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bchc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bchc_pkg::CfgW-1:0]     cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          level_i,
  input  wire logic [bchc_pkg::TimeW-1:0]    now_ms_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [bchc_pkg::EventW-1:0]   event_res_o
);

  bchc_pkg::cfg_t cfg;

  logic                         in_valid_q;
  logic                         level_q;
  logic [bchc_pkg::TimeW-1:0]   now_ms_q;
  logic                         out_valid_q;
  logic [bchc_pkg::EventW-1:0]  event_res_q;
  logic [bchc_pkg::EventW-1:0]  event_d;
  logic                         step;
  logic                         in_xfer;

  // advance the held sample when the result register is free or draining
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;
  assign in_xfer    = in_valid_i && in_ready_o;

  bchc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bchc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .level_i  (level_q),
    .now_ms_i (now_ms_q),
    .cfg_i    (cfg),
    .event_o  (event_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      level_q  <= level_i;
      now_ms_q <= now_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      event_res_q <= event_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = event_res_q;

endmodule

`default_nettype wire

// ===== src/bchc_cfg.sv =====
// Configuration register file for the button click/hold classifier.
// Depends on bchc_pkg for indexes, reset values and cfg_t.
`default_nettype none

module bchc_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bchc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bchc_pkg::CfgW-1:0]     cfg_wdata_i,
  output bchc_pkg::cfg_t                     cfg_o
);

  bchc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms         <= bchc_pkg::DebounceRst;
      cfg_q.double_click_gap_ms <= bchc_pkg::DblGapRst;
      cfg_q.hold_ms             <= bchc_pkg::HoldRst;
      cfg_q.long_hold_ms        <= bchc_pkg::LongHoldRst;
    end else if (cfg_we_i) begin
      // indexes past the last register are dropped
      unique case (cfg_idx_i)
        bchc_pkg::RegDebounce: cfg_q.debounce_ms         <= cfg_wdata_i;
        bchc_pkg::RegDblGap:   cfg_q.double_click_gap_ms <= cfg_wdata_i;
        bchc_pkg::RegHold:     cfg_q.hold_ms             <= cfg_wdata_i;
        bchc_pkg::RegLongHold: cfg_q.long_hold_ms        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== src/bchc_core.sv =====
// Classifier state and per-sample event logic.
// Depends on bchc_pkg; updates its state on every step_i.
`default_nettype none

module bchc_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire logic                         level_i,
  input  wire logic [bchc_pkg::TimeW-1:0]   now_ms_i,
  input  wire bchc_pkg::cfg_t               cfg_i,
  output logic      [bchc_pkg::EventW-1:0]  event_o
);

  localparam int unsigned TW = bchc_pkg::TimeW;

  logic          last_level_q, last_level_d;
  logic [TW-1:0] press_time_q, press_time_d;
  logic [TW-1:0] release_time_q, release_time_d;
  logic          dbl_wait_q, dbl_wait_d;
  logic          dbl_on_rel_q, dbl_on_rel_d;
  logic          single_ok_q, single_ok_d;
  logic          ign_rel_q, ign_rel_d;
  logic          hold_done_q, hold_done_d;
  logic          long_done_q, long_done_d;

  logic [TW-1:0] since_up, since_down, since_up2, since_down2;
  logic [TW-1:0] deb_w, gap_w, hold_w, long_w;
  logic          press_upd, rel_upd;
  logic [bchc_pkg::EventW-1:0] ev;

  assign deb_w  = {{(TW-bchc_pkg::CfgW){1'b0}}, cfg_i.debounce_ms};
  assign gap_w  = {{(TW-bchc_pkg::CfgW){1'b0}}, cfg_i.double_click_gap_ms};
  assign hold_w = {{(TW-bchc_pkg::CfgW){1'b0}}, cfg_i.hold_ms};
  assign long_w = {{(TW-bchc_pkg::CfgW){1'b0}}, cfg_i.long_hold_ms};

  assign since_up   = now_ms_i - release_time_q;
  assign since_down = now_ms_i - press_time_q;

  always_comb begin
    last_level_d   = level_i;
    press_time_d   = press_time_q;
    release_time_d = release_time_q;
    dbl_wait_d     = dbl_wait_q;
    dbl_on_rel_d   = dbl_on_rel_q;
    single_ok_d    = single_ok_q;
    ign_rel_d      = ign_rel_q;
    hold_done_d    = hold_done_q;
    long_done_d    = long_done_q;
    press_upd      = 1'b0;
    rel_upd        = 1'b0;
    ev             = bchc_pkg::EvNone;

    priority if (!level_i && last_level_q && (since_up > deb_w)) begin
      press_time_d = now_ms_i;
      press_upd    = 1'b1;
      ign_rel_d    = 1'b0;
      single_ok_d  = 1'b1;
      hold_done_d  = 1'b0;
      long_done_d  = 1'b0;
      dbl_on_rel_d = (since_up < gap_w) && !dbl_on_rel_q && dbl_wait_q;
      dbl_wait_d   = 1'b0;
    end else if (level_i && !last_level_q && (since_down > deb_w)) begin
      if (!ign_rel_q) begin
        release_time_d = now_ms_i;
        rel_upd        = 1'b1;
        priority if (!dbl_on_rel_q) begin
          dbl_wait_d = 1'b1;
        end else if (!hold_done_q) begin
          ev           = bchc_pkg::EvDouble;
          dbl_on_rel_d = 1'b0;
          dbl_wait_d   = 1'b0;
          single_ok_d  = 1'b0;
        end else if (long_done_q) begin
          ev = bchc_pkg::EvLong;
        end else begin
        end
      end else if (!long_done_q) begin
        ev = bchc_pkg::EvHold;
      end
    end else begin
    end

    // after an edge the matching stamp equals now, so its age is zero
    since_up2   = rel_upd   ? '0 : since_up;
    since_down2 = press_upd ? '0 : since_down;

    // single click once the double-click gap has run out
    if (level_i && (since_up2 >= gap_w) && dbl_wait_d && !dbl_on_rel_d && single_ok_d &&
        (ev != bchc_pkg::EvDouble)) begin
      ev         = bchc_pkg::EvClick;
      dbl_wait_d = 1'b0;
    end

    if (!level_i && (since_down2 >= hold_w)) begin
      if (!hold_done_d) begin
        ign_rel_d    = 1'b1;
        dbl_on_rel_d = 1'b0;
        dbl_wait_d   = 1'b0;
        hold_done_d  = 1'b1;
      end
      if ((since_down2 >= long_w) && !long_done_d) begin
        ev          = bchc_pkg::EvLong;
        long_done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q   <= 1'b1;
      press_time_q   <= '1;
      release_time_q <= '1;
      dbl_wait_q     <= 1'b0;
      dbl_on_rel_q   <= 1'b0;
      single_ok_q    <= 1'b1;
      ign_rel_q      <= 1'b0;
      hold_done_q    <= 1'b0;
      long_done_q    <= 1'b0;
    end else if (step_i) begin
      last_level_q   <= last_level_d;
      press_time_q   <= press_time_d;
      release_time_q <= release_time_d;
      dbl_wait_q     <= dbl_wait_d;
      dbl_on_rel_q   <= dbl_on_rel_d;
      single_ok_q    <= single_ok_d;
      ign_rel_q      <= ign_rel_d;
      hold_done_q    <= hold_done_d;
      long_done_q    <= long_done_d;
    end
  end

  assign event_o = ev;

endmodule

`default_nettype wire

// ===== dv/bchc_event_checker.sv =====
// Scoreboard for the button click/hold classifier: tracks timing register
// writes, predicts one event code per accepted sample and compares results.
// Depends on bchc_pkg.
module bchc_event_checker
  import bchc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_o,
  input  logic                level_i,
  input  logic [TimeW-1:0]    now_ms_i,
  input  logic                out_valid_o,
  input  logic                out_ready_i,
  input  logic [EventW-1:0]   event_res_o,
  output int unsigned         fail_cnt_o,
  output int unsigned         pending_cnt_o
);

  cfg_t timing;

  // classifier state as the predictor sees it
  logic             btn_prev;
  logic [TimeW-1:0] t_press;
  logic [TimeW-1:0] t_release;
  logic             dbl_armed;
  logic             dbl_pending;
  logic             click_ok;
  logic             skip_release;
  logic             held;
  logic             long_held;

  logic [EventW-1:0] expected_events [$];

  task automatic classify_sample(input logic lvl, input logic [TimeW-1:0] t,
                                 output logic [EventW-1:0] ev);
    logic [TimeW-1:0] up;
    logic [TimeW-1:0] down;
    ev   = EvNone;
    up   = t - t_release;
    down = t - t_press;
    if (!lvl && btn_prev && up > timing.debounce_ms) begin
      t_press      = t;
      skip_release = 1'b0;
      click_ok     = 1'b1;
      held         = 1'b0;
      long_held    = 1'b0;
      dbl_pending  = (up < timing.double_click_gap_ms) && !dbl_pending && dbl_armed;
      dbl_armed    = 1'b0;
    end else if (lvl && !btn_prev && down > timing.debounce_ms) begin
      if (!skip_release) begin
        t_release = t;
        if (!dbl_pending) begin
          dbl_armed = 1'b1;
        end else if (!held) begin
          ev          = EvDouble;
          dbl_pending = 1'b0;
          dbl_armed   = 1'b0;
          click_ok    = 1'b0;
        end else if (long_held) begin
          ev = EvLong;
        end
      end else if (!long_held) begin
        ev = EvHold;
      end
    end

    up   = t - t_release;
    down = t - t_press;

    // single click once the double-click window has run out
    if (lvl && up >= timing.double_click_gap_ms && dbl_armed && !dbl_pending &&
        click_ok && ev != EvDouble) begin
      ev        = EvClick;
      dbl_armed = 1'b0;
    end

    if (!lvl && down >= timing.hold_ms) begin
      if (!held) begin
        skip_release = 1'b1;
        dbl_pending  = 1'b0;
        dbl_armed    = 1'b0;
        held         = 1'b1;
      end
      if (down >= timing.long_hold_ms && !long_held) begin
        ev        = EvLong;
        long_held = 1'b1;
      end
    end
    btn_prev = lvl;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [EventW-1:0] ev;
    logic [EventW-1:0] want;
    if (!rst_ni) begin
      timing.debounce_ms         = DebounceRst;
      timing.double_click_gap_ms = DblGapRst;
      timing.hold_ms             = HoldRst;
      timing.long_hold_ms        = LongHoldRst;
      btn_prev     = 1'b1;
      t_press      = '1;
      t_release    = '1;
      dbl_armed    = 1'b0;
      dbl_pending  = 1'b0;
      click_ok     = 1'b1;
      skip_release = 1'b0;
      held         = 1'b0;
      long_held    = 1'b0;
      expected_events.delete();
      fail_cnt_o    = 0;
      pending_cnt_o = 0;
    end else begin
      // check the result first so a same-edge sample cannot hide a stray one
      if (out_valid_o && out_ready_i) begin
        if (expected_events.size() == 0) begin
          fail_cnt_o++;
          $display("%0t: unexpected event %0d with nothing outstanding",
                   $time, event_res_o);
        end else begin
          want = expected_events.pop_front();
          if (event_res_o !== want) begin
            fail_cnt_o++;
            $display("%0t: event_res mismatch: expected %0d, actual %0d",
                     $time, want, event_res_o);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        classify_sample(level_i, now_ms_i, ev);
        expected_events.push_back(ev);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegDebounce: timing.debounce_ms         = cfg_wdata_i;
          RegDblGap:   timing.double_click_gap_ms = cfg_wdata_i;
          RegHold:     timing.hold_ms             = cfg_wdata_i;
          RegLongHold: timing.long_hold_ms        = cfg_wdata_i;
          default: ;
        endcase
      end
      pending_cnt_o = expected_events.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the button click/hold classifier testbench: clock, reset, sample
// stimulus built from press/release gestures, timing register phases, verdict.
// Depends on bchc_pkg, button_click_hold_classifier and bchc_event_checker.
module testbench;
  import bchc_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               level_i;
  logic [TimeW-1:0]   now_ms_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [EventW-1:0]  event_res_o;

  int unsigned fail_cnt;
  int unsigned pending_cnt;

  // stimulus-side copy of the timing registers, used to aim at thresholds
  int unsigned dbn_ms, gap_ms, hold_ms, long_ms;
  logic [TimeW-1:0] now_cur;
  int unsigned      phase_items;
  bit               steady;

  button_click_hold_classifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .level_i     (level_i),
    .now_ms_i    (now_ms_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .event_res_o (event_res_o)
  );

  bchc_event_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .level_i       (level_i),
    .now_ms_i      (now_ms_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_res_o   (event_res_o),
    .fail_cnt_o    (fail_cnt),
    .pending_cnt_o (pending_cnt)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // mostly short pauses, now and then a long one
  function automatic int unsigned pick_pause();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // a value one below, at or one above a threshold
  function automatic int unsigned near(input int unsigned th);
    int unsigned v;
    v = th + $urandom_range(0, 2);
    return (v == 0) ? 0 : v - 1;
  endfunction

  // receiver back-pressure
  initial begin : rx_stall
    int unsigned stall_left;
    out_ready_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!steady && $urandom_range(0, 4) == 0) stall_left = pick_pause();
      end
    end
  end

  // one input transaction; returns at the edge it is accepted
  task automatic offer_sample(input logic lvl, input logic [TimeW-1:0] t);
    int unsigned gap;
    gap = (!steady && $urandom_range(0, 2) == 0) ? pick_pause() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    level_i    <= lvl;
    now_ms_i   <= t;
    do @(posedge clk_i); while (!in_ready_o);
    phase_items++;
  endtask

  // button held at one level for dur ms, sampled n times in that span
  task automatic hold_level(input logic lvl, input int unsigned dur, input int unsigned n);
    int unsigned rem;
    int unsigned step;
    rem = dur;
    offer_sample(lvl, now_cur);
    for (int i = 1; i < n; i++) begin
      step    = $urandom_range(0, rem);
      rem     -= step;
      now_cur += step;
      offer_sample(lvl, now_cur);
    end
    now_cur += rem;
  endtask

  task automatic play_gesture();
    int unsigned kind;
    kind   = $urandom_range(0, 11);
    steady = ($urandom_range(0, 7) == 0);
    case (kind)
      0, 1, 2: begin // single click
        hold_level(1'b0, dbn_ms + 1 + $urandom_range(0, gap_ms + 5), $urandom_range(1, 2));
        hold_level(1'b1, near(gap_ms) + $urandom_range(0, 1), $urandom_range(1, 3));
        hold_level(1'b1, $urandom_range(0, gap_ms + 10), 1);
      end
      3, 4: begin // double click
        hold_level(1'b0, dbn_ms + 1 + $urandom_range(0, gap_ms + 5), $urandom_range(1, 2));
        hold_level(1'b1, dbn_ms + 1 + $urandom_range(0, gap_ms), $urandom_range(1, 2));
        hold_level(1'b0, dbn_ms + 1 + $urandom_range(0, hold_ms + 5), $urandom_range(1, 3));
        hold_level(1'b1, near(gap_ms) + $urandom_range(0, gap_ms), $urandom_range(1, 3));
      end
      5, 6: begin // hold
        hold_level(1'b0, near(hold_ms) + $urandom_range(0, long_ms / 2), $urandom_range(1, 4));
        hold_level(1'b1, near(gap_ms) + dbn_ms, $urandom_range(1, 2));
      end
      7: begin // long hold
        hold_level(1'b0, near(long_ms) + $urandom_range(0, long_ms / 4), $urandom_range(2, 5));
        hold_level(1'b1, dbn_ms + 1 + $urandom_range(0, gap_ms), $urandom_range(1, 2));
      end
      8: begin // contact bounce inside the debounce window
        hold_level(1'($urandom_range(0, 1)), $urandom_range(0, dbn_ms + 2), 1);
      end
      9: begin // clock jump, forwards or backwards
        now_cur += $urandom;
        hold_level(1'($urandom_range(0, 1)), $urandom_range(0, 50), 1);
      end
      default: begin
        hold_level(1'($urandom_range(0, 1)), $urandom_range(0, 2 * long_ms + 300),
                   $urandom_range(1, 3));
      end
    endcase
  endtask

  // let every outstanding result drain before touching the registers
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_cnt != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic cfg_apply(input logic [CfgW-1:0] d, input logic [CfgW-1:0] g,
                           input logic [CfgW-1:0] h, input logic [CfgW-1:0] l);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= RegDebounce;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_idx_i   <= RegDblGap;
    cfg_wdata_i <= g;
    @(posedge clk_i);
    cfg_idx_i   <= RegHold;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_idx_i   <= RegLongHold;
    cfg_wdata_i <= l;
    // unmapped index, must leave all timing registers alone
    @(posedge clk_i);
    cfg_idx_i   <= RegLongHold + CfgIdxW'($urandom_range(1, 4));
    cfg_wdata_i <= CfgW'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dbn_ms  = 32'(d);
    gap_ms  = 32'(g);
    hold_ms = 32'(h);
    long_ms = 32'(l);
  endtask

  initial begin : stimulus
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = RegDebounce;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    level_i     = 1'b1;
    now_ms_i    = '0;
    steady      = 1'b0;
    phase_items = 0;
    dbn_ms  = 32'(DebounceRst);
    gap_ms  = 32'(DblGapRst);
    hold_ms = 32'(HoldRst);
    long_ms = 32'(LongHoldRst);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed walk under the reset timings
    offer_sample(1'b1, 32'd0);
    offer_sample(1'b0, 32'd5);     // press lost in debounce window after reset
    offer_sample(1'b1, 32'd10);    // release lost too
    offer_sample(1'b0, 32'd100);
    offer_sample(1'b1, 32'd200);
    offer_sample(1'b1, 32'd400);   // click after the gap runs out
    offer_sample(1'b0, 32'd500);
    offer_sample(1'b1, 32'd560);
    offer_sample(1'b0, 32'd600);
    offer_sample(1'b1, 32'd680);   // double click
    offer_sample(1'b0, 32'd1000);
    offer_sample(1'b0, 32'd2100);
    offer_sample(1'b1, 32'd2200);  // hold reported on release
    offer_sample(1'b0, 32'd3000);
    offer_sample(1'b0, 32'd5000);  // long hold while pressed
    offer_sample(1'b1, 32'd5100);  // release after long hold: nothing
    offer_sample(1'b0, 32'hFFFF_FFF0);
    offer_sample(1'b1, 32'h0000_0010);  // press spans the wrap
    offer_sample(1'b1, 32'hFFFF_FFFF);  // time runs backwards
    offer_sample(1'b0, 32'h8000_0000);
    offer_sample(1'b1, 32'h7FFF_FFFF);
    offer_sample(1'b1, 32'h8000_1000);
    now_cur = 32'h8000_2000;

    for (int phase = 0; phase < 7; phase++) begin
      if (phase > 0) begin
        wait_idle();
        case (phase)
          1: cfg_apply('0, '0, '0, '0);
          2: cfg_apply('1, '1, '1, '1);
          3: cfg_apply(CfgW'($urandom_range(0, 4)), CfgW'($urandom_range(0, 40)),
                       CfgW'($urandom_range(0, 120)), CfgW'($urandom_range(0, 250)));
          4: cfg_apply(CfgW'($urandom), CfgW'($urandom), CfgW'($urandom), CfgW'($urandom));
          5: cfg_apply('1, '0, '1, '0);
          default: cfg_apply(CfgW'($urandom_range(0, 10)), CfgW'($urandom_range(5, 60)),
                             CfgW'($urandom_range(20, 200)),
                             CfgW'($urandom_range(100, 400)));
        endcase
      end
      phase_items = 0;
      while (phase_items < 120) play_gesture();
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #6_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/bchc_pkg.sv
src/bchc_cfg.sv
src/bchc_core.sv
src/button_click_hold_classifier.sv
dv/bchc_event_checker.sv
dv/testbench.sv
